// ===== rtl/core/trw_pkg.sv =====
package trw_pkg;

  localparam int unsigned WORD_W    = 32;
  localparam int unsigned HALF_W    = 16;
  localparam int unsigned KIND_W    = 2;
  localparam int unsigned CFG_IDX_W = 2;

  localparam int unsigned MAX_BURST = 64;
  localparam int unsigned BURST_W   = $clog2(MAX_BURST + 1);
  localparam int unsigned DIV_CNT_W = $clog2(WORD_W);

  typedef logic [WORD_W-1:0] word_t;
  typedef logic [HALF_W-1:0] half_t;

  localparam logic [KIND_W-1:0] KIND_ACK     = 2'd0;
  localparam logic [KIND_W-1:0] KIND_TIMEOUT = 2'd1;
  localparam logic [KIND_W-1:0] KIND_APPEND  = 2'd2;
  localparam logic [KIND_W-1:0] KIND_SEND    = 2'd3;

  localparam logic [CFG_IDX_W-1:0] REG_SEG_SIZE  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_INIT_WND  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_INIT_THR  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_START_SEQ = 2'd3;

  localparam half_t RST_SEG_SIZE  = 16'd1400;
  localparam word_t RST_INIT_WND  = 32'd1400;
  localparam word_t RST_INIT_THR  = 32'd65535;
  localparam word_t RST_START_SEQ = 32'd0;
  localparam half_t RST_PEER_WIN  = 16'hFFFF;

endpackage

// ===== rtl/core/trw_in_if.sv =====
interface trw_in_if import trw_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [KIND_W-1:0] kind;
  word_t             ack_number;
  half_t             peer_window;
  half_t             append_bytes;

  modport source (output valid, kind, ack_number, peer_window, append_bytes, input ready);
  modport sink (input valid, kind, ack_number, peer_window, append_bytes, output ready);
endinterface

// ===== rtl/core/trw_out_if.sv =====
interface trw_out_if import trw_pkg::*; ();
  logic  valid;
  logic  ready;
  word_t seg_seq;
  half_t seg_len;
  word_t window_now;
  word_t threshold_now;
  logic  retransmit;
  logic  last;

  modport source (output valid, seg_seq, seg_len, window_now, threshold_now, retransmit, last,
                  input ready);
  modport sink (input valid, seg_seq, seg_len, window_now, threshold_now, retransmit, last,
                output ready);
endinterface

// ===== rtl/core/tcp_reno_window_control.sv =====
// TCP Reno sender window bookkeeping: one input transaction at a time. Ready is high only
// while the sequencer is idle. A new ACK in slow start, a duplicate ACK, a timeout, an
// append or a send opportunity that emits nothing passes from decode to the response
// state and puts out one result transaction. A new ACK in congestion avoidance first waits
// for the 32-step divider that forms MSS*MSS/cwnd. A send opportunity that emits segments
// puts them out one after another (up to 64), each segment leaving through the output
// register as one transaction.
// The sink can hold back any result or segment by holding ready low.
module tcp_reno_window_control import trw_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  word_t                cfg_data_i,
  trw_in_if.sink               in_i,
  trw_out_if.source            out_o
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_MUL,
    S_DIV,
    S_SEND,
    S_RESP
  } state_e;

  function automatic word_t sat_add(word_t a, word_t b);
    logic [WORD_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[WORD_W] ? '1 : s[WORD_W-1:0];
  endfunction

  state_e state_q;

  half_t mss_q;

  word_t       cwnd_q;
  word_t       ssthresh_q;
  logic [1:0]  dup_q;
  word_t       acked_q;
  word_t       sent_q;
  word_t       written_q;
  half_t       peer_q;

  logic [KIND_W-1:0] kind_q;
  word_t             ack_q;
  half_t             pw_q;
  half_t             ab_q;
  logic              rt_q;
  word_t             prod_q;
  word_t             avail_q;
  word_t             pend_q;
  logic [BURST_W-1:0] n_q;

  logic  out_valid_q;
  word_t out_seq_q;
  half_t out_len_q;
  word_t out_wnd_q;
  word_t out_thr_q;
  logic  out_rt_q;
  logic  out_last_q;

  logic  in_accept;
  logic  emit_ok;
  logic  out_load;
  logic  div_start;
  logic  div_done;
  word_t div_quo;

  word_t ack_m1;
  word_t ack_dist;
  word_t sent_dist;
  logic  new_ack;
  logic  dup_ack;
  logic  ack_past_sent;
  word_t mss_w;
  word_t cwnd_plus_mss;
  word_t fr_thr;
  word_t fr_cwnd;
  logic  slow_start;
  word_t base;
  word_t outst;
  word_t avail;
  word_t pend;
  logic  can_send;
  word_t len_a;
  word_t len_w;
  logic  seg_last;

  assign in_accept = in_i.valid && in_i.ready;
  assign in_i.ready = state_q == S_IDLE;
  assign emit_ok   = !out_valid_q || out_o.ready;
  assign out_load  = (state_q inside {S_SEND, S_RESP}) && emit_ok;
  assign div_start = state_q == S_MUL;

  always_comb begin
    ack_m1        = ack_q - 1'b1;
    ack_dist      = ack_m1 - acked_q;
    sent_dist     = ack_m1 - sent_q;
    new_ack       = ack_dist != '0 && !ack_dist[WORD_W-1];
    dup_ack       = ack_dist == '0;
    ack_past_sent = sent_dist != '0 && !sent_dist[WORD_W-1];
    mss_w         = {{(WORD_W-HALF_W){1'b0}}, mss_q};
    cwnd_plus_mss = sat_add(cwnd_q, mss_w);
    fr_thr        = cwnd_q >> 1;
    fr_cwnd       = sat_add(fr_thr, (mss_w << 1) + mss_w);
    slow_start    = cwnd_q < ssthresh_q || cwnd_q == '0;
    base          = (cwnd_q < {{(WORD_W-HALF_W){1'b0}}, peer_q}) ? cwnd_q :
                    {{(WORD_W-HALF_W){1'b0}}, peer_q};
    outst         = sent_q - acked_q;
    avail         = (base > outst) ? base - outst : '0;
    pend          = written_q - sent_q;
    can_send      = !(dup_q == 2'd1 || dup_q == 2'd2) && mss_q != '0 && avail != '0 &&
                    pend != '0 && !pend[WORD_W-1];
    len_a         = (avail_q < pend_q) ? avail_q : pend_q;
    len_w         = (len_a > mss_w) ? mss_w : len_a;
    seg_last      = n_q == BURST_W'(MAX_BURST - 1) || avail_q == len_w || pend_q == len_w;
  end

  trw_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (prod_q),
    .divisor_i  (cwnd_q),
    .done_o     (div_done),
    .quotient_o (div_quo)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      mss_q       <= RST_SEG_SIZE;
      cwnd_q      <= RST_INIT_WND;
      ssthresh_q  <= RST_INIT_THR;
      dup_q       <= '0;
      acked_q     <= RST_START_SEQ;
      sent_q      <= RST_START_SEQ;
      written_q   <= RST_START_SEQ;
      peer_q      <= RST_PEER_WIN;
      kind_q      <= KIND_ACK;
      ack_q       <= '0;
      pw_q        <= '0;
      ab_q        <= '0;
      rt_q        <= 1'b0;
      prod_q      <= '0;
      avail_q     <= '0;
      pend_q      <= '0;
      n_q         <= '0;
      out_valid_q <= 1'b0;
      out_seq_q   <= '0;
      out_len_q   <= '0;
      out_wnd_q   <= '0;
      out_thr_q   <= '0;
      out_rt_q    <= 1'b0;
      out_last_q  <= 1'b0;
    end else begin
      if (out_o.ready && !out_load) begin
        out_valid_q <= 1'b0;
      end

      case (state_q)
        S_IDLE: begin
          if (in_accept) begin
            kind_q  <= in_i.kind;
            ack_q   <= in_i.ack_number;
            pw_q    <= in_i.peer_window;
            ab_q    <= in_i.append_bytes;
            state_q <= S_DECODE;
          end
        end

        S_DECODE: begin
          rt_q    <= 1'b0;
          state_q <= S_RESP;
          case (kind_q)
            KIND_ACK: begin
              peer_q <= pw_q;
              if (new_ack) begin
                dup_q   <= '0;
                acked_q <= ack_m1;
                if (ack_past_sent) begin
                  sent_q <= ack_m1;
                end
                if (slow_start) begin
                  cwnd_q <= cwnd_plus_mss;
                end else begin
                  prod_q  <= WORD_W'(mss_q) * WORD_W'(mss_q);
                  state_q <= S_MUL;
                end
              end else if (dup_ack) begin
                if (dup_q == 2'd3) begin
                  cwnd_q <= cwnd_plus_mss;
                end else if (dup_q == 2'd2) begin
                  dup_q      <= 2'd3;
                  ssthresh_q <= fr_thr;
                  cwnd_q     <= fr_cwnd;
                  sent_q     <= acked_q;
                  rt_q       <= 1'b1;
                end else begin
                  dup_q  <= dup_q + 1'b1;
                  cwnd_q <= cwnd_plus_mss;
                end
              end
            end
            KIND_TIMEOUT: begin
              dup_q      <= '0;
              ssthresh_q <= fr_thr;
              cwnd_q     <= mss_w;
              sent_q     <= acked_q;
              rt_q       <= 1'b1;
            end
            KIND_APPEND: begin
              written_q <= written_q + {{(WORD_W-HALF_W){1'b0}}, ab_q};
            end
            KIND_SEND: begin
              avail_q <= avail;
              pend_q  <= pend;
              n_q     <= '0;
              if (can_send) begin
                state_q <= S_SEND;
              end
            end
            default: begin
              state_q <= S_RESP;
            end
          endcase
        end

        S_MUL: begin
          state_q <= S_DIV;
        end

        S_DIV: begin
          if (div_done) begin
            cwnd_q  <= sat_add(cwnd_q, div_quo);
            state_q <= S_RESP;
          end
        end

        S_SEND: begin
          if (emit_ok) begin
            out_valid_q <= 1'b1;
            out_seq_q   <= sent_q + 1'b1;
            out_len_q   <= len_w[HALF_W-1:0];
            out_wnd_q   <= cwnd_q;
            out_thr_q   <= ssthresh_q;
            out_rt_q    <= 1'b0;
            out_last_q  <= seg_last;
            sent_q      <= sent_q + len_w;
            avail_q     <= avail_q - len_w;
            pend_q      <= pend_q - len_w;
            n_q         <= n_q + 1'b1;
            if (seg_last) begin
              state_q <= S_IDLE;
            end
          end
        end

        S_RESP: begin
          if (emit_ok) begin
            out_valid_q <= 1'b1;
            out_seq_q   <= '0;
            out_len_q   <= '0;
            out_wnd_q   <= cwnd_q;
            out_thr_q   <= ssthresh_q;
            out_rt_q    <= rt_q;
            out_last_q  <= 1'b1;
            state_q     <= S_IDLE;
          end
        end

        default: begin
          state_q <= S_IDLE;
        end
      endcase

      // the user must write config only while no transaction is in flight; the block does not enforce this
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_SEG_SIZE: begin
            mss_q <= cfg_data_i[HALF_W-1:0];
          end
          REG_INIT_WND: begin
            cwnd_q <= cfg_data_i;
          end
          REG_INIT_THR: begin
            ssthresh_q <= cfg_data_i;
          end
          REG_START_SEQ: begin
            acked_q   <= cfg_data_i;
            sent_q    <= cfg_data_i;
            written_q <= cfg_data_i;
          end
          default: begin
            mss_q <= mss_q;
          end
        endcase
      end
    end
  end

  assign out_o.valid         = out_valid_q;
  assign out_o.seg_seq       = out_seq_q;
  assign out_o.seg_len       = out_len_q;
  assign out_o.window_now    = out_wnd_q;
  assign out_o.threshold_now = out_thr_q;
  assign out_o.retransmit    = out_rt_q;
  assign out_o.last          = out_last_q;

endmodule

// ===== rtl/core/trw_div.sv =====
module trw_div import trw_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  start_i,
  input  word_t dividend_i,
  input  word_t divisor_i,
  output logic  done_o,
  output word_t quotient_o
);

  logic                 busy_q;
  logic                 done_q;
  logic [DIV_CNT_W-1:0] cnt_q;
  word_t                rem_q;
  word_t                quo_q;
  word_t                dvs_q;
  logic [WORD_W:0]      rem_sh;
  logic [WORD_W:0]      diff;
  logic                 ge;

  // restoring division, one quotient bit per cycle
  assign rem_sh = {rem_q, quo_q[WORD_W-1]};
  assign ge     = rem_sh >= {1'b0, dvs_q};
  assign diff   = rem_sh - {1'b0, dvs_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == DIV_CNT_W'(WORD_W - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      quo_q <= dividend_i;
      dvs_q <= divisor_i;
    end else if (busy_q) begin
      rem_q <= ge ? diff[WORD_W-1:0] : rem_sh[WORD_W-1:0];
      quo_q <= {quo_q[WORD_W-2:0], ge};
    end
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule
